// ----- rtl/swsa_pkg.sv -----
// ----------------------------------------------------------------------------
// swsa_pkg: shared types and constants for the windowed sensor statistics block
// Channel and colour codes, register indexes, the alarm priority encoder and
// the result record passed back from the mean divider.
// ----------------------------------------------------------------------------
package swsa_pkg;

  // sample channels
  localparam int NUM_CHAN = 7;
  localparam int CHAN_W   = 3;
  localparam int VAL_W    = 15;
  localparam int COL_W    = 2;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 3;

  localparam logic [CHAN_W-1:0] CH_TEMP  = 3'd0;
  localparam logic [CHAN_W-1:0] CH_HUM   = 3'd1;
  localparam logic [CHAN_W-1:0] CH_LIGHT = 3'd2;
  localparam logic [CHAN_W-1:0] CH_SOIL  = 3'd3;
  localparam logic [CHAN_W-1:0] CH_X     = 3'd4;
  localparam logic [CHAN_W-1:0] CH_Y     = 3'd5;
  localparam logic [CHAN_W-1:0] CH_Z     = 3'd6;

  // accumulator reset values
  localparam logic signed [VAL_W-1:0] VAL_MAX = 15'sh3fff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 15'sh4000;

  // colour codes
  localparam logic [COL_W-1:0] COL_UNKNOWN = 2'd0;
  localparam logic [COL_W-1:0] COL_RED     = 2'd1;
  localparam logic [COL_W-1:0] COL_GREEN   = 2'd2;
  localparam logic [COL_W-1:0] COL_BLUE    = 2'd3;

  // result kinds
  localparam logic KIND_ALARM = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_LO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_HI   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SOIL_LO  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SOIL_HI  = 3'd7;

  // limit reset values
  localparam logic signed [14:0] TEMP_LO_RST  = 15'sd1500;
  localparam logic signed [14:0] TEMP_HI_RST  = 15'sd3000;
  localparam logic [13:0]        HUM_LO_RST   = 14'd3000;
  localparam logic [13:0]        HUM_HI_RST   = 14'd7000;
  localparam logic [9:0]         LIGHT_LO_RST = 10'd100;
  localparam logic [9:0]         LIGHT_HI_RST = 10'd800;
  localparam logic [9:0]         SOIL_LO_RST  = 10'd200;
  localparam logic [9:0]         SOIL_HI_RST  = 10'd800;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
  } rgb_t;

  // one finished mean from the divide pipeline
  typedef struct packed {
    logic              vld;
    logic [CHAN_W-1:0] chan;
    logic [VAL_W-1:0]  mean;
  } mean_res_t;

  // highest-priority failed check picks the alarm colour
  function automatic rgb_t alarm_rgb(input logic [NUM_CHAN-1:0] oor,
                                     input logic [COL_W-1:0] colour);
    rgb_t c;
    c = '0;
    priority if (oor[CH_TEMP]) begin
      c.red = 1'b1;
    end else if (oor[CH_HUM]) begin
      c.blue = 1'b1;
    end else if (oor[CH_LIGHT]) begin
      c.green = 1'b1;
    end else if (oor[CH_SOIL]) begin
      c.red   = 1'b1;
      c.green = 1'b1;
    end else if (oor[CH_X] || oor[CH_Y] || oor[CH_Z]) begin
      c.green = 1'b1;
      c.blue  = 1'b1;
    end else if (colour != COL_GREEN) begin
      c.red  = 1'b1;
      c.blue = 1'b1;
    end else begin
      // all checks pass, leds off
      c = '0;
    end
    return c;
  endfunction

endpackage

// ----- rtl/swsa_lane.sv -----
// ----------------------------------------------------------------------------
// swsa_lane: one channel of the statistics datapath
// Range check against a low and high limit, and running sum, min and max of
// the channel over the current window.
// ----------------------------------------------------------------------------
module swsa_lane
  import swsa_pkg::*;
#(
  parameter int SUM_W = 22
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  logic                    clr,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] lim_lo,
  input  logic signed [VAL_W-1:0] lim_hi,
  output logic                    oor,
  output logic signed [SUM_W-1:0] sum_nxt,
  output logic signed [VAL_W-1:0] min_nxt,
  output logic signed [VAL_W-1:0] max_nxt
);

  logic signed [SUM_W-1:0] sum_r;
  logic signed [VAL_W-1:0] min_r;
  logic signed [VAL_W-1:0] max_r;

  // range check
  assign oor = (value < lim_lo) || (value > lim_hi);

  // values including the current sample
  assign sum_nxt = sum_r + SUM_W'(value);
  assign min_nxt = (value < min_r) ? value : min_r;
  assign max_nxt = (value > max_r) ? value : max_r;

  // window accumulators, cleared when the window closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      min_r <= VAL_MAX;
      max_r <= VAL_MIN;
    end else if (upd) begin
      if (clr) begin
        sum_r <= '0;
        min_r <= VAL_MAX;
        max_r <= VAL_MIN;
      end else begin
        sum_r <= sum_nxt;
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

endmodule

// ----- rtl/swsa_mean_div.sv -----
// ----------------------------------------------------------------------------
// swsa_mean_div: window sum divided by the window length
// Four-stage pipeline: magnitude, reciprocal multiply, back-multiply for the
// remainder, then a one-step correction and the sign. Truncates toward zero.
// ----------------------------------------------------------------------------
module swsa_mean_div
  import swsa_pkg::*;
#(
  parameter int WINDOW_LEN = 120
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             iss_vld,
  input  logic [CHAN_W-1:0]                                iss_chan,
  input  logic signed [VAL_W+$clog2(WINDOW_LEN+1)-1:0]     iss_sum,
  output mean_res_t                                        res
);

  localparam int SUM_W  = VAL_W + $clog2(WINDOW_LEN + 1);
  localparam longint unsigned RECIP = (64'd1 << SUM_W) / WINDOW_LEN;
  localparam int M_W    = $clog2(RECIP + 1);
  localparam int PROD_W = SUM_W + M_W;

  // stage 1: magnitude and sign
  logic                vld1_r, vld2_r, vld3_r;
  logic [CHAN_W-1:0]   chan1_r, chan2_r, chan3_r;
  logic                neg1_r, neg2_r, neg3_r;
  logic [SUM_W-1:0]    mag1_r, mag2_r;
  logic [PROD_W-1:0]   prod;
  logic [VAL_W-1:0]    q0_2_r, q0_3_r;
  logic [SUM_W-1:0]    rem_nxt, rem3_r;
  logic [VAL_W-1:0]    quo;
  logic                res_vld_r;
  logic [CHAN_W-1:0]   res_chan_r;
  logic [VAL_W-1:0]    res_mean_r;

  // quotient estimate, low by at most one
  assign prod    = PROD_W'(mag1_r) * PROD_W'(RECIP);
  assign rem_nxt = mag2_r - SUM_W'(q0_2_r) * SUM_W'(WINDOW_LEN);
  assign quo     = (rem3_r >= SUM_W'(WINDOW_LEN)) ? q0_3_r + VAL_W'(1) : q0_3_r;

  // valid tokens
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      vld1_r    <= iss_vld;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      res_vld_r <= vld3_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    chan1_r    <= iss_chan;
    neg1_r     <= iss_sum[SUM_W-1];
    mag1_r     <= iss_sum[SUM_W-1] ? SUM_W'(-iss_sum) : SUM_W'(iss_sum);
    chan2_r    <= chan1_r;
    neg2_r     <= neg1_r;
    mag2_r     <= mag1_r;
    q0_2_r     <= prod[SUM_W +: VAL_W];
    chan3_r    <= chan2_r;
    neg3_r     <= neg2_r;
    q0_3_r     <= q0_2_r;
    rem3_r     <= rem_nxt;
    res_chan_r <= chan3_r;
    res_mean_r <= neg3_r ? VAL_W'(-quo) : quo;
  end

  assign res = '{vld: res_vld_r, chan: res_chan_r, mean: res_mean_r};

endmodule

// ----- rtl/swsa_merge.sv -----
// ----------------------------------------------------------------------------
// swsa_merge: window bookkeeping and result sequencer
// Counts samples and colours, latches the lane results when the window closes,
// feeds the sums to the divider and sends the alarm and statistics results.
// ----------------------------------------------------------------------------
module swsa_merge
  import swsa_pkg::*;
#(
  parameter int WINDOW_LEN = 120
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // sample side
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [COL_W-1:0]                              colour,
  output logic                                          sample_fire,
  output logic                                          win_full,
  // lanes
  input  logic [NUM_CHAN-1:0]                           oor,
  input  logic signed [VAL_W+$clog2(WINDOW_LEN+1)-1:0]  sum_nxt [NUM_CHAN],
  input  logic signed [VAL_W-1:0]                       min_nxt [NUM_CHAN],
  input  logic signed [VAL_W-1:0]                       max_nxt [NUM_CHAN],
  // divider
  output logic                                          iss_vld,
  output logic [CHAN_W-1:0]                             iss_chan,
  output logic signed [VAL_W+$clog2(WINDOW_LEN+1)-1:0]  iss_sum,
  input  mean_res_t                                     div_res,
  // result side
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic                                          out_result_kind,
  output logic                                          out_led_red,
  output logic                                          out_led_green,
  output logic                                          out_led_blue,
  output logic [CHAN_W-1:0]                             out_channel,
  output logic signed [VAL_W-1:0]                       out_window_mean,
  output logic signed [VAL_W-1:0]                       out_window_min,
  output logic signed [VAL_W-1:0]                       out_window_max,
  output logic [COL_W-1:0]                              out_majority_colour,
  output logic                                          out_is_last
);

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = VAL_W + CNT_W;
  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHAN - 1);
  localparam logic [CHAN_W-1:0] LAST_EMIT = CHAN_W'(NUM_CHAN);

  // window counters
  logic [CNT_W-1:0] cnt_r, red_r, green_r, blue_r;
  logic [CNT_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [COL_W-1:0] maj;

  // job state
  logic              busy_r, stats_r;
  logic [CHAN_W-1:0] emit_idx_r;
  logic              iss_act_r;
  logic [CHAN_W-1:0] iss_cnt_r;
  logic [NUM_CHAN-1:0] mean_vld_r;
  rgb_t              alarm_r;
  logic [COL_W-1:0]  maj_r;
  logic signed [SUM_W-1:0] sum_snap_r [NUM_CHAN];
  logic signed [VAL_W-1:0] min_snap_r [NUM_CHAN];
  logic signed [VAL_W-1:0] max_snap_r [NUM_CHAN];
  logic [VAL_W-1:0]        mean_r [NUM_CHAN];

  // output register
  logic              out_valid_r;
  logic              kind_r, red_o_r, green_o_r, blue_o_r, last_o_r;
  logic [CHAN_W-1:0] chan_o_r;
  logic signed [VAL_W-1:0] mean_o_r, min_o_r, max_o_r;
  logic [COL_W-1:0]  maj_o_r;

  // sequencer controls
  logic              out_free, item_rdy, load, last_item, job_done;
  logic [CHAN_W-1:0] chan_sel;

  assign win_full = (cnt_r == CNT_W'(WINDOW_LEN - 1));

  assign chan_sel  = (emit_idx_r == '0) ? '0 : emit_idx_r - CHAN_W'(1);
  assign out_free  = !out_valid_r || !out_stall;
  assign item_rdy  = busy_r && ((emit_idx_r == '0) || mean_vld_r[chan_sel]);
  assign load      = out_free && item_rdy;
  assign last_item = ((emit_idx_r == '0) && !stats_r) || (emit_idx_r == LAST_EMIT);
  assign job_done  = load && last_item;

  // a new sample can enter in the cycle its predecessor's last result is loaded
  assign in_stall    = busy_r && !job_done;
  assign sample_fire = in_valid && !in_stall;

  // colour tallies including the current sample
  assign red_nxt   = red_r   + CNT_W'(colour == COL_RED);
  assign green_nxt = green_r + CNT_W'(colour == COL_GREEN);
  assign blue_nxt  = blue_r  + CNT_W'(colour == COL_BLUE);

  // majority colour, ties to red then green
  always_comb begin
    priority if ((red_nxt == '0) && (green_nxt == '0) && (blue_nxt == '0)) begin
      maj = COL_UNKNOWN;
    end else if ((red_nxt >= green_nxt) && (red_nxt >= blue_nxt)) begin
      maj = COL_RED;
    end else if (green_nxt >= blue_nxt) begin
      maj = COL_GREEN;
    end else begin
      maj = COL_BLUE;
    end
  end

  // divider feed
  assign iss_vld  = iss_act_r;
  assign iss_chan = iss_cnt_r;
  assign iss_sum  = sum_snap_r[iss_cnt_r];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      busy_r      <= 1'b0;
      stats_r     <= 1'b0;
      emit_idx_r  <= '0;
      iss_act_r   <= 1'b0;
      iss_cnt_r   <= '0;
      mean_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (sample_fire) begin
        cnt_r   <= win_full ? '0 : cnt_r + CNT_W'(1);
        red_r   <= win_full ? '0 : red_nxt;
        green_r <= win_full ? '0 : green_nxt;
        blue_r  <= win_full ? '0 : blue_nxt;
        // start a new job
        busy_r     <= 1'b1;
        stats_r    <= win_full;
        emit_idx_r <= '0;
        iss_act_r  <= win_full;
        iss_cnt_r  <= '0;
        mean_vld_r <= '0;
      end else begin
        if (load) begin
          emit_idx_r <= emit_idx_r + CHAN_W'(1);
          if (last_item) begin
            busy_r <= 1'b0;
          end
        end
        if (iss_act_r) begin
          iss_cnt_r <= iss_cnt_r + CHAN_W'(1);
          if (iss_cnt_r == LAST_CHAN) begin
            iss_act_r <= 1'b0;
          end
        end
        if (div_res.vld) begin
          mean_vld_r[div_res.chan] <= 1'b1;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      alarm_r <= alarm_rgb(oor, colour);
      maj_r   <= maj;
      if (win_full) begin
        for (int i = 0; i < NUM_CHAN; i++) begin
          sum_snap_r[i] <= sum_nxt[i];
          min_snap_r[i] <= min_nxt[i];
          max_snap_r[i] <= max_nxt[i];
        end
      end
    end
    if (div_res.vld) begin
      mean_r[div_res.chan] <= div_res.mean;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      last_o_r <= last_item;
      if (emit_idx_r == '0) begin
        kind_r    <= KIND_ALARM;
        red_o_r   <= alarm_r.red;
        green_o_r <= alarm_r.green;
        blue_o_r  <= alarm_r.blue;
        chan_o_r  <= '0;
        mean_o_r  <= '0;
        min_o_r   <= '0;
        max_o_r   <= '0;
        maj_o_r   <= COL_UNKNOWN;
      end else begin
        kind_r    <= KIND_STATS;
        red_o_r   <= 1'b0;
        green_o_r <= 1'b0;
        blue_o_r  <= 1'b0;
        chan_o_r  <= chan_sel;
        mean_o_r  <= $signed(mean_r[chan_sel]);
        min_o_r   <= min_snap_r[chan_sel];
        max_o_r   <= max_snap_r[chan_sel];
        maj_o_r   <= maj_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_led_red         = red_o_r;
  assign out_led_green       = green_o_r;
  assign out_led_blue        = blue_o_r;
  assign out_channel         = chan_o_r;
  assign out_window_mean     = mean_o_r;
  assign out_window_min      = min_o_r;
  assign out_window_max      = max_o_r;
  assign out_majority_colour = maj_o_r;
  assign out_is_last         = last_o_r;

endmodule

// ----- rtl/sensor_window_stats_alarm.sv -----
// ----------------------------------------------------------------------------
// sensor_window_stats_alarm: windowed sensor statistics with a priority alarm
// Seven channel lanes check limits and accumulate sum, min and max; a merge
// stage counts colours, feeds the sums to the divider and sends the results in order.
// ----------------------------------------------------------------------------
// Every sample yields one alarm result; the sample that closes a window of
// WINDOW_LEN samples also yields seven statistics results, one per channel,
// with is_last on the last result of each sample. A sample that does not
// close the window needs only its alarm result loaded, so samples can be
// accepted every cycle while the result side keeps up. A window-closing
// sample stalls the input while its window sums go one per cycle through a
// shared four-stage reciprocal divide pipeline and the eight results leave
// through one output register at one per cycle while the output is not
// stalled; output stalls lengthen the input stall. The next sample is
// accepted in the cycle the final result of the previous one is loaded.
// The user must write limits through the cfg port only while no sample is
// in flight; the block itself does not enforce this.
module sensor_window_stats_alarm
  import swsa_pkg::*;
#(
  parameter int WINDOW_LEN  = 120,
  parameter int ACCEL_LIMIT = 200
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [14:0]   in_temperature,
  input  logic [13:0]          in_humidity,
  input  logic [9:0]           in_light_level,
  input  logic [9:0]           in_soil_moisture,
  input  logic signed [11:0]   in_accel_x,
  input  logic signed [11:0]   in_accel_y,
  input  logic signed [11:0]   in_accel_z,
  input  logic [1:0]           in_colour_code,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_result_kind,
  output logic                 out_led_red,
  output logic                 out_led_green,
  output logic                 out_led_blue,
  output logic [2:0]           out_channel,
  output logic signed [14:0]   out_window_mean,
  output logic signed [14:0]   out_window_min,
  output logic signed [14:0]   out_window_max,
  output logic [1:0]           out_majority_colour,
  output logic                 out_is_last
);

  localparam int SUM_W = VAL_W + $clog2(WINDOW_LEN + 1);
  localparam logic signed [VAL_W-1:0] ACC_HI = VAL_W'(ACCEL_LIMIT);
  localparam logic signed [VAL_W-1:0] ACC_LO = -ACC_HI;

  // limit registers
  logic signed [14:0] temp_lo_r, temp_hi_r;
  logic [13:0]        hum_lo_r, hum_hi_r;
  logic [9:0]         light_lo_r, light_hi_r;
  logic [9:0]         soil_lo_r, soil_hi_r;

  // lane wiring
  logic signed [VAL_W-1:0] lane_val [NUM_CHAN];
  logic signed [VAL_W-1:0] lane_lo  [NUM_CHAN];
  logic signed [VAL_W-1:0] lane_hi  [NUM_CHAN];
  logic signed [SUM_W-1:0] sum_nxt  [NUM_CHAN];
  logic signed [VAL_W-1:0] min_nxt  [NUM_CHAN];
  logic signed [VAL_W-1:0] max_nxt  [NUM_CHAN];
  logic [NUM_CHAN-1:0]     oor;
  logic                    sample_fire, win_full;

  // divider wiring
  logic                    iss_vld;
  logic [CHAN_W-1:0]       iss_chan;
  logic signed [SUM_W-1:0] iss_sum;
  mean_res_t               div_res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_lo_r  <= TEMP_LO_RST;
      temp_hi_r  <= TEMP_HI_RST;
      hum_lo_r   <= HUM_LO_RST;
      hum_hi_r   <= HUM_HI_RST;
      light_lo_r <= LIGHT_LO_RST;
      light_hi_r <= LIGHT_HI_RST;
      soil_lo_r  <= SOIL_LO_RST;
      soil_hi_r  <= SOIL_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_LO:  temp_lo_r  <= $signed(cfg_wdata);
        REG_TEMP_HI:  temp_hi_r  <= $signed(cfg_wdata);
        REG_HUM_LO:   hum_lo_r   <= cfg_wdata[13:0];
        REG_HUM_HI:   hum_hi_r   <= cfg_wdata[13:0];
        REG_LIGHT_LO: light_lo_r <= cfg_wdata[9:0];
        REG_LIGHT_HI: light_hi_r <= cfg_wdata[9:0];
        REG_SOIL_LO:  soil_lo_r  <= cfg_wdata[9:0];
        REG_SOIL_HI:  soil_hi_r  <= cfg_wdata[9:0];
      endcase
    end
  end

  // common 15-bit signed view of each channel and its limits
  always_comb begin
    lane_val[CH_TEMP]  = in_temperature;
    lane_val[CH_HUM]   = $signed(VAL_W'(in_humidity));
    lane_val[CH_LIGHT] = $signed(VAL_W'(in_light_level));
    lane_val[CH_SOIL]  = $signed(VAL_W'(in_soil_moisture));
    lane_val[CH_X]     = VAL_W'(in_accel_x);
    lane_val[CH_Y]     = VAL_W'(in_accel_y);
    lane_val[CH_Z]     = VAL_W'(in_accel_z);

    lane_lo[CH_TEMP]  = temp_lo_r;
    lane_hi[CH_TEMP]  = temp_hi_r;
    lane_lo[CH_HUM]   = $signed(VAL_W'(hum_lo_r));
    lane_hi[CH_HUM]   = $signed(VAL_W'(hum_hi_r));
    lane_lo[CH_LIGHT] = $signed(VAL_W'(light_lo_r));
    lane_hi[CH_LIGHT] = $signed(VAL_W'(light_hi_r));
    lane_lo[CH_SOIL]  = $signed(VAL_W'(soil_lo_r));
    lane_hi[CH_SOIL]  = $signed(VAL_W'(soil_hi_r));
    lane_lo[CH_X]     = ACC_LO;
    lane_hi[CH_X]     = ACC_HI;
    lane_lo[CH_Y]     = ACC_LO;
    lane_hi[CH_Y]     = ACC_HI;
    lane_lo[CH_Z]     = ACC_LO;
    lane_hi[CH_Z]     = ACC_HI;
  end

  // channel lanes
  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
    swsa_lane #(
      .SUM_W (SUM_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .upd     (sample_fire),
      .clr     (win_full),
      .value   (lane_val[i]),
      .lim_lo  (lane_lo[i]),
      .lim_hi  (lane_hi[i]),
      .oor     (oor[i]),
      .sum_nxt (sum_nxt[i]),
      .min_nxt (min_nxt[i]),
      .max_nxt (max_nxt[i])
    );
  end

  // shared mean divider
  swsa_mean_div #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss_vld  (iss_vld),
    .iss_chan (iss_chan),
    .iss_sum  (iss_sum),
    .res      (div_res)
  );

  // merge and result sequencing
  swsa_merge #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .colour              (in_colour_code),
    .sample_fire         (sample_fire),
    .win_full            (win_full),
    .oor                 (oor),
    .sum_nxt             (sum_nxt),
    .min_nxt             (min_nxt),
    .max_nxt             (max_nxt),
    .iss_vld             (iss_vld),
    .iss_chan            (iss_chan),
    .iss_sum             (iss_sum),
    .div_res             (div_res),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_led_red         (out_led_red),
    .out_led_green       (out_led_green),
    .out_led_blue        (out_led_blue),
    .out_channel         (out_channel),
    .out_window_mean     (out_window_mean),
    .out_window_min      (out_window_min),
    .out_window_max      (out_window_max),
    .out_majority_colour (out_majority_colour),
    .out_is_last         (out_is_last)
  );

endmodule

// ----- tb/sensor_window_stats_alarm_tb.sv -----
// ----------------------------------------------------------------------------
// sensor_window_stats_alarm_tb: self-checking bench for the sensor statistics
// Drives samples with random gaps and output stalls. A tracker class keeps its
// own copy of the limits and window state, predicts the alarm and statistics
// results of every sample, and compares each result field by field.
// ----------------------------------------------------------------------------
module sensor_window_stats_alarm_tb
  import swsa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_LEN      = 120;
  localparam int ACCEL_MAX    = 200;
  localparam int PHASE_ITEMS  = 21;
  localparam int NUM_PHASES   = 5;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    logic signed [14:0] temperature;
    logic [13:0]        humidity;
    logic [9:0]         light;
    logic [9:0]         soil;
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [11:0] az;
    logic [1:0]         colour;
  } sample_t;

  typedef struct {
    logic               kind;
    logic               red;
    logic               green;
    logic               blue;
    logic [2:0]         channel;
    logic signed [14:0] mean;
    logic signed [14:0] wmin;
    logic signed [14:0] wmax;
    logic [1:0]         maj;
    logic               last;
  } result_t;

  // predicts alarm and window statistics, holds the results still due
  class alarm_stats_tracker;
    int      temp_lo, temp_hi, hum_lo, hum_hi;
    int      light_lo, light_hi, soil_lo, soil_hi;
    longint  chan_sum [NUM_CHAN];
    int      chan_min [NUM_CHAN];
    int      chan_max [NUM_CHAN];
    int      red_cnt, green_cnt, blue_cnt, sample_cnt;
    result_t due_results[$];
    int      errors;

    function new();
      temp_lo  = TEMP_LO_RST;
      temp_hi  = TEMP_HI_RST;
      hum_lo   = HUM_LO_RST;
      hum_hi   = HUM_HI_RST;
      light_lo = LIGHT_LO_RST;
      light_hi = LIGHT_HI_RST;
      soil_lo  = SOIL_LO_RST;
      soil_hi  = SOIL_HI_RST;
      errors   = 0;
      clear_window();
    endfunction

    function void clear_window();
      for (int i = 0; i < NUM_CHAN; i++) begin
        chan_sum[i] = 0;
        chan_min[i] = VAL_MAX;
        chan_max[i] = VAL_MIN;
      end
      red_cnt    = 0;
      green_cnt  = 0;
      blue_cnt   = 0;
      sample_cnt = 0;
    endfunction

    function void note_config(logic [2:0] idx, logic [14:0] val);
      case (idx)
        REG_TEMP_LO:  temp_lo  = int'($signed(val));
        REG_TEMP_HI:  temp_hi  = int'($signed(val));
        REG_HUM_LO:   hum_lo   = int'(val[13:0]);
        REG_HUM_HI:   hum_hi   = int'(val[13:0]);
        REG_LIGHT_LO: light_lo = int'(val[9:0]);
        REG_LIGHT_HI: light_hi = int'(val[9:0]);
        REG_SOIL_LO:  soil_lo  = int'(val[9:0]);
        REG_SOIL_HI:  soil_hi  = int'(val[9:0]);
        default: ;
      endcase
    endfunction

    function bit axis_over(int a);
      return (a < 0 ? -a : a) > ACCEL_MAX;
    endfunction

    function void add_sample(sample_t s);
      int         v [NUM_CHAN];
      result_t    alarm;
      result_t    stat;
      logic [1:0] maj;
      v[CH_TEMP]  = s.temperature;
      v[CH_HUM]   = s.humidity;
      v[CH_LIGHT] = s.light;
      v[CH_SOIL]  = s.soil;
      v[CH_X]     = s.ax;
      v[CH_Y]     = s.ay;
      v[CH_Z]     = s.az;

      // accumulate the window
      for (int i = 0; i < NUM_CHAN; i++) begin
        chan_sum[i] += v[i];
        if (v[i] < chan_min[i]) chan_min[i] = v[i];
        if (v[i] > chan_max[i]) chan_max[i] = v[i];
      end
      if (s.colour == COL_RED) red_cnt++;
      else if (s.colour == COL_GREEN) green_cnt++;
      else if (s.colour == COL_BLUE) blue_cnt++;
      sample_cnt++;

      // alarm colour by check priority
      alarm = '{default: '0};
      alarm.kind = KIND_ALARM;
      if (v[CH_TEMP] < temp_lo || v[CH_TEMP] > temp_hi) begin
        alarm.red = 1'b1;
      end else if (v[CH_HUM] < hum_lo || v[CH_HUM] > hum_hi) begin
        alarm.blue = 1'b1;
      end else if (v[CH_LIGHT] < light_lo || v[CH_LIGHT] > light_hi) begin
        alarm.green = 1'b1;
      end else if (v[CH_SOIL] < soil_lo || v[CH_SOIL] > soil_hi) begin
        alarm.red   = 1'b1;
        alarm.green = 1'b1;
      end else if (axis_over(v[CH_X]) || axis_over(v[CH_Y]) || axis_over(v[CH_Z])) begin
        alarm.green = 1'b1;
        alarm.blue  = 1'b1;
      end else if (s.colour != COL_GREEN) begin
        alarm.red  = 1'b1;
        alarm.blue = 1'b1;
      end
      alarm.last = (sample_cnt < WIN_LEN);
      due_results.push_back(alarm);
      if (sample_cnt < WIN_LEN) return;

      // window full: majority colour, ties favor red then green
      if (red_cnt == 0 && green_cnt == 0 && blue_cnt == 0) maj = COL_UNKNOWN;
      else if (red_cnt >= green_cnt && red_cnt >= blue_cnt) maj = COL_RED;
      else if (green_cnt >= blue_cnt) maj = COL_GREEN;
      else maj = COL_BLUE;

      for (int i = 0; i < NUM_CHAN; i++) begin
        stat = '{default: '0};
        stat.kind    = KIND_STATS;
        stat.channel = 3'(i);
        stat.mean    = 15'(chan_sum[i] / longint'(sample_cnt));
        stat.wmin    = 15'(chan_min[i]);
        stat.wmax    = 15'(chan_max[i]);
        stat.maj     = maj;
        stat.last    = (i == NUM_CHAN - 1);
        due_results.push_back(stat);
      end
      clear_window();
    endfunction

    function void cmp_field(string name, logic signed [31:0] exp_v,
                            logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (due_results.size() == 0) begin
        $display("%0t: result transfer with no result due (kind %0d, channel %0d)",
                 $time, got.kind, got.channel);
        errors++;
        return;
      end
      exp_r = due_results.pop_front();
      cmp_field("result_kind", exp_r.kind, got.kind);
      cmp_field("led_red", exp_r.red, got.red);
      cmp_field("led_green", exp_r.green, got.green);
      cmp_field("led_blue", exp_r.blue, got.blue);
      cmp_field("channel", exp_r.channel, got.channel);
      cmp_field("window_mean", exp_r.mean, got.mean);
      cmp_field("window_min", exp_r.wmin, got.wmin);
      cmp_field("window_max", exp_r.wmax, got.wmax);
      cmp_field("majority_colour", exp_r.maj, got.maj);
      cmp_field("is_last", exp_r.last, got.last);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [14:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [14:0] in_temperature = '0;
  logic [13:0]        in_humidity = '0;
  logic [9:0]         in_light_level = '0;
  logic [9:0]         in_soil_moisture = '0;
  logic signed [11:0] in_accel_x = '0;
  logic signed [11:0] in_accel_y = '0;
  logic signed [11:0] in_accel_z = '0;
  logic [1:0]         in_colour_code = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_result_kind;
  logic               out_led_red;
  logic               out_led_green;
  logic               out_led_blue;
  logic [2:0]         out_channel;
  logic signed [14:0] out_window_mean;
  logic signed [14:0] out_window_min;
  logic signed [14:0] out_window_max;
  logic [1:0]         out_majority_colour;
  logic               out_is_last;

  alarm_stats_tracker tracker;
  bit                 calm = 1'b0;
  int                 cycles = 0;
  int                 stall_left = 0;

  sensor_window_stats_alarm #(
    .WINDOW_LEN (WIN_LEN),
    .ACCEL_LIMIT(ACCEL_MAX)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_temperature     (in_temperature),
    .in_humidity        (in_humidity),
    .in_light_level     (in_light_level),
    .in_soil_moisture   (in_soil_moisture),
    .in_accel_x         (in_accel_x),
    .in_accel_y         (in_accel_y),
    .in_accel_z         (in_accel_z),
    .in_colour_code     (in_colour_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_led_red        (out_led_red),
    .out_led_green      (out_led_green),
    .out_led_blue       (out_led_blue),
    .out_channel        (out_channel),
    .out_window_mean    (out_window_mean),
    .out_window_min     (out_window_min),
    .out_window_max     (out_window_max),
    .out_majority_colour(out_majority_colour),
    .out_is_last        (out_is_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, tracker.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short pauses, a few long ones
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return pick_pause();
  endfunction

  // result side: check each transfer, then decide next stall
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind    = out_result_kind;
      got.red     = out_led_red;
      got.green   = out_led_green;
      got.blue    = out_led_blue;
      got.channel = out_channel;
      got.mean    = out_window_mean;
      got.wmin    = out_window_min;
      got.wmax    = out_window_max;
      got.maj     = out_majority_colour;
      got.last    = out_is_last;
      tracker.check_result(got);
    end
    if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30) stall_left = pick_pause();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic sample_t mk_sample(int t, int h, int l, int s, int x, int y, int z,
                                        logic [1:0] c);
    sample_t smp;
    smp.temperature = 15'(t);
    smp.humidity    = 14'(h);
    smp.light       = 10'(l);
    smp.soil        = 10'(s);
    smp.ax          = 12'(x);
    smp.ay          = 12'(y);
    smp.az          = 12'(z);
    smp.colour      = c;
    return smp;
  endfunction

  // mostly nominal, some anywhere in range, a few anywhere in the field width
  function automatic int pick_value(int nom_lo, int nom_hi, int rng_lo, int rng_hi,
                                    int width);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return nom_lo + int'($urandom_range(0, nom_hi - nom_lo));
    if (r < 94) return rng_lo + int'($urandom_range(0, rng_hi - rng_lo));
    return int'($urandom & ((32'd1 << width) - 1));
  endfunction

  function automatic sample_t random_sample();
    logic [1:0] c;
    c = ($urandom_range(0, 99) < 55) ? COL_GREEN : 2'($urandom_range(0, 3));
    return mk_sample(pick_value(1500, 3000, -4000, 12500, 15),
                     pick_value(3000, 7000, 0, 10000, 14),
                     pick_value(100, 800, 0, 1000, 10),
                     pick_value(200, 800, 0, 1000, 10),
                     pick_value(-200, 200, -1600, 1600, 12),
                     pick_value(-200, 200, -1600, 1600, 12),
                     pick_value(-200, 200, -1600, 1600, 12),
                     c);
  endfunction

  // one input transfer; valid stays high when the next sample follows at once
  task automatic send_sample(sample_t s, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_temperature   <= s.temperature;
    in_humidity      <= s.humidity;
    in_light_level   <= s.light;
    in_soil_moisture <= s.soil;
    in_accel_x       <= s.ax;
    in_accel_y       <= s.ay;
    in_accel_z       <= s.az;
    in_colour_code   <= s.colour;
    do @(posedge clk); while (in_stall);
    tracker.add_sample(s);
  endtask

  // hold off input until every due result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [2:0] idx, logic [14:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.note_config(idx, val);
  endtask

  task automatic set_limits(int tlo, int thi, int hlo, int hhi,
                            int llo, int lhi, int slo, int shi);
    write_limit(REG_TEMP_LO, 15'(tlo));
    write_limit(REG_TEMP_HI, 15'(thi));
    write_limit(REG_HUM_LO, 15'(hlo));
    write_limit(REG_HUM_HI, 15'(hhi));
    write_limit(REG_LIGHT_LO, 15'(llo));
    write_limit(REG_LIGHT_HI, 15'(lhi));
    write_limit(REG_SOIL_LO, 15'(slo));
    write_limit(REG_SOIL_HI, 15'(shi));
    cfg_we <= 1'b0;
  endtask

  // random pair inside the stated range, sometimes inverted, with junk above the field
  function automatic int rand_limit(int rng_lo, int rng_hi, int width, bit upper, bit swap);
    int a;
    int b;
    int t;
    a = rng_lo + int'($urandom_range(0, rng_hi - rng_lo));
    b = rng_lo + int'($urandom_range(0, rng_hi - rng_lo));
    if ((a > b) != swap) begin
      t = a;
      a = b;
      b = t;
    end
    t = upper ? b : a;
    if (width < 15) t = (t & ((1 << width) - 1)) | (int'($urandom) << width);
    return t;
  endfunction

  task automatic set_random_limits();
    bit sw;
    sw = ($urandom_range(0, 99) < 20);
    write_limit(REG_TEMP_LO, 15'(rand_limit(-4000, 12500, 15, 1'b0, sw)));
    write_limit(REG_TEMP_HI, 15'(rand_limit(-4000, 12500, 15, 1'b1, 1'b0)));
    write_limit(REG_HUM_LO, 15'(rand_limit(0, 10000, 14, 1'b0, 1'b0)));
    write_limit(REG_HUM_HI, 15'(rand_limit(3000, 10000, 14, 1'b1, 1'b0)));
    write_limit(REG_LIGHT_LO, 15'(rand_limit(0, 300, 10, 1'b0, 1'b0)));
    write_limit(REG_LIGHT_HI, 15'(rand_limit(500, 1000, 10, 1'b1, 1'b0)));
    write_limit(REG_SOIL_LO, 15'(rand_limit(0, 300, 10, 1'b0, 1'b0)));
    write_limit(REG_SOIL_HI, 15'(rand_limit(500, 1000, 10, 1'b1, 1'b0)));
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    sample_t directed[$];
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset limits: boundaries, each check, priority, field extremes
    directed.push_back(mk_sample(2000, 5000, 500, 500, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(1500, 3000, 100, 200, 200, -200, 200, COL_GREEN));
    directed.push_back(mk_sample(3000, 7000, 800, 800, -200, 200, -200, COL_GREEN));
    directed.push_back(mk_sample(1499, 5000, 500, 500, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(3001, 5000, 500, 500, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 2999, 500, 500, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 7001, 500, 500, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 5000, 99, 500, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 5000, 801, 500, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 5000, 500, 199, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 5000, 500, 801, 0, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 5000, 500, 500, 201, 0, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 5000, 500, 500, 0, -201, 0, COL_GREEN));
    directed.push_back(mk_sample(2000, 5000, 500, 500, 0, 0, 201, COL_GREEN));
    directed.push_back(mk_sample(2000, 5000, 500, 500, 0, 0, 0, COL_UNKNOWN));
    directed.push_back(mk_sample(2000, 5000, 500, 500, 0, 0, 0, COL_RED));
    directed.push_back(mk_sample(2000, 5000, 500, 500, 0, 0, 0, COL_BLUE));
    directed.push_back(mk_sample(0, 0, 0, 0, 0, 0, 0, COL_UNKNOWN));
    directed.push_back(mk_sample(16383, 16383, 1023, 1023, 2047, 2047, 2047, COL_BLUE));
    directed.push_back(mk_sample(-16384, 0, 0, 0, -2048, -2048, -2048, COL_UNKNOWN));
    directed.push_back(mk_sample(-4000, 0, 0, 0, -1600, -1600, -1600, COL_GREEN));
    directed.push_back(mk_sample(12500, 10000, 1000, 1000, 1600, 1600, 1600, COL_RED));
    directed.push_back(mk_sample(2000, 9000, 500, 900, 0, 0, 0, COL_RED));
    directed.push_back(mk_sample(2000, 5000, 20, 500, -900, 0, 0, COL_BLUE));
    foreach (directed[i]) send_sample(directed[i], pick_gap());

    // random phases, each under its own limit setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_limits(-16384, 16383, 0, 16383, 0, 1023, 0, 1023);
        1: set_limits(12500, -4000, 10000, 0, 1000, 0, 1000, 0);
        2: set_random_limits();
        3: set_random_limits();
        default: set_limits(TEMP_LO_RST, TEMP_HI_RST, HUM_LO_RST, HUM_HI_RST,
                            LIGHT_LO_RST, LIGHT_HI_RST, SOIL_LO_RST, SOIL_HI_RST);
      endcase
      calm = (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 3) drain();
        send_sample(random_sample(), pick_gap());
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
